[hdl/itmr_pkg.sv]
// ----------------------------------------------------------------------------
// itmr_pkg
// Shared codes, reset values, command struct and count helpers for the
// three channel interval timer.
// ----------------------------------------------------------------------------
package itmr_pkg;

  // bus beat action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // port offset of the control word
  localparam logic [1:0] PORT_CTRL = 2'd3;

  // channel field of a control word that means readback
  localparam logic [1:0] CH_READBACK = 2'd3;

  // read/write mode codes, control word bits 5:4
  localparam logic [1:0] RW_LATCH = 2'd0;
  localparam logic [1:0] RW_LSB   = 2'd1;
  localparam logic [1:0] RW_MSB   = 2'd2;
  localparam logic [1:0] RW_WORD  = 2'd3;

  // counting modes
  localparam logic [2:0] MODE_RATE   = 3'd2;
  localparam logic [2:0] MODE_SQUARE = 3'd3;
  localparam logic [2:0] MODE_FIRST_DEAD = 3'd6;

  localparam logic [7:0]  CTRL_READ_BYTE = 8'hFF;
  localparam logic [7:0]  STATUS_MASK    = 8'h3F;
  localparam logic [7:0]  STATUS_NULL    = 8'h40;
  localparam logic [15:0] BCD_LIMIT      = 16'h9999;
  localparam logic [15:0] BIN_LIMIT      = 16'hFFFF;

  localparam logic [7:0]  RESET_CW0     = 8'h36;
  localparam logic [7:0]  RESET_CW1     = 8'h74;
  localparam logic [7:0]  RESET_CW2     = 8'hB6;
  localparam logic [15:0] RESET_RELOAD0 = 16'hFFFF;
  localparam logic [15:0] RESET_RELOAD1 = 16'h0012;
  localparam logic [15:0] RESET_RELOAD2 = 16'h0001;

  // per channel command decoded from one bus beat
  typedef struct packed {
    logic       tick;
    logic       rd;
    logic       wr;
    logic       prog;
    logic       latch;
    logic       status;
    logic [7:0] data;
  } chan_cmd_t;

  function automatic logic [7:0] reset_cw(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = RESET_CW0;
      2'd1:    r = RESET_CW1;
      default: r = RESET_CW2;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] reset_reload(input logic [1:0] idx);
    logic [15:0] r;
    case (idx)
      2'd0:    r = RESET_RELOAD0;
      2'd1:    r = RESET_RELOAD1;
      default: r = RESET_RELOAD2;
    endcase
    return r;
  endfunction

  // each nibble taken modulo ten
  function automatic logic [15:0] bcd_fix(input logic [15:0] v);
    logic [15:0] r;
    logic [3:0]  nib;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      nib = v[4*i +: 4];
      r[4*i +: 4] = (nib > 4'd9) ? (nib - 4'd10) : nib;
    end
    return r;
  endfunction

  // decimal decrement of a valid bcd word (never called with zero)
  function automatic logic [15:0] bcd_dec(input logic [15:0] v);
    logic [15:0] r;
    logic [3:0]  nib;
    logic        borrow;
    r      = v;
    borrow = 1'b1;
    for (int i = 0; i < 4; i++) begin
      nib = v[4*i +: 4];
      if (borrow) begin
        if (nib == 4'd0) begin
          r[4*i +: 4] = 4'd9;
        end else begin
          r[4*i +: 4] = nib - 4'd1;
          borrow      = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // start value in the count encoding (bcd digits in bcd mode)
  function automatic logic [15:0] start_value(input logic [15:0] reload, input logic bcd);
    return bcd ? bcd_fix(reload) : reload;
  endfunction

  function automatic logic mode_runs(input logic [7:0] cw);
    return cw[3:1] < MODE_FIRST_DEAD;
  endfunction

  function automatic logic [15:0] count_limit(input logic [7:0] cw, input logic [15:0] reload);
    logic [15:0] r;
    if (cw[3:1] == MODE_RATE || cw[3:1] == MODE_SQUARE) begin
      r = start_value(reload, cw[0]);
    end else begin
      r = cw[0] ? BCD_LIMIT : BIN_LIMIT;
    end
    return r;
  endfunction

endpackage

[hdl/itmr_if.sv]
// ----------------------------------------------------------------------------
// itmr_if
// Valid/ready channels of the interval timer: bus beat in, read byte out.
// ----------------------------------------------------------------------------
interface itmr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] port_select;
  logic [7:0] data;

  modport source (output valid, output action, output port_select, output data,
                  input ready);
  modport sink (input valid, input action, input port_select, input data,
                output ready);
endinterface

interface itmr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink (input valid, input read_data, output ready);
endinterface

[hdl/itmr_channel.sv]
// ----------------------------------------------------------------------------
// itmr_channel
// One counter channel: control word, reload, count, latch and byte toggles.
// ----------------------------------------------------------------------------
module itmr_channel #(
  parameter int CH_ID = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itmr_pkg::chan_cmd_t  cmd,
  output logic [7:0]           rd_byte
);

  logic [7:0]  cw_r, cw_nxt;
  logic [15:0] reload_r, reload_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] latched_r, latched_nxt;
  logic        rt_r, rt_nxt;
  logic        wt_r, wt_nxt;
  logic        lv_r, lv_nxt;
  logic        lp_r, lp_nxt;
  logic        sp_r, sp_nxt;

  logic [15:0] cur_val;
  logic [15:0] rd_val;
  logic [15:0] lim;
  logic [15:0] reload_new;
  logic        wt_new;
  logic [7:0]  rst_cw;
  logic [15:0] rst_reload;

  assign rst_cw     = itmr_pkg::reset_cw(2'(CH_ID));
  assign rst_reload = itmr_pkg::reset_reload(2'(CH_ID));

  // visible count, zero while a load is pending or the mode is dead
  assign cur_val = (lp_r || !itmr_pkg::mode_runs(cw_r)) ? 16'd0 : count_r;
  assign rd_val  = lv_r ? latched_r : cur_val;
  assign lim     = itmr_pkg::count_limit(cw_r, reload_r);

  // next state for the one command of this beat
  always_comb begin
    cw_nxt      = cw_r;
    reload_nxt  = reload_r;
    count_nxt   = count_r;
    latched_nxt = latched_r;
    rt_nxt      = rt_r;
    wt_nxt      = wt_r;
    lv_nxt      = lv_r;
    lp_nxt      = lp_r;
    sp_nxt      = sp_r;
    rd_byte     = 8'd0;
    reload_new  = reload_r;
    wt_new      = wt_r;

    // timer tick: decrement, wrap at the limit
    if (cmd.tick && !lp_r && itmr_pkg::mode_runs(cw_r)) begin
      if (count_r == 16'd0 || count_r > lim) begin
        count_nxt = lim;
      end else if (cw_r[0]) begin
        count_nxt = itmr_pkg::bcd_dec(count_r);
      end else begin
        count_nxt = count_r - 16'd1;
      end
    end

    // counter read: status byte first, then count bytes
    if (cmd.rd) begin
      if (sp_r) begin
        sp_nxt  = 1'b0;
        rd_byte = (cw_r & itmr_pkg::STATUS_MASK) | (lp_r ? itmr_pkg::STATUS_NULL : 8'd0);
      end else begin
        unique case (cw_r[5:4])
          itmr_pkg::RW_LSB: begin
            lv_nxt  = 1'b0;
            rd_byte = rd_val[7:0];
          end
          itmr_pkg::RW_MSB: begin
            lv_nxt  = 1'b0;
            rd_byte = rd_val[15:8];
          end
          itmr_pkg::RW_WORD: begin
            rt_nxt = !rt_r;
            if (!rt_r) begin
              rd_byte = rd_val[7:0];
            end else begin
              lv_nxt  = 1'b0;
              rd_byte = rd_val[15:8];
            end
          end
          itmr_pkg::RW_LATCH: begin
            rd_byte = 8'd0;
          end
        endcase
      end
    end

    // counter write: reload bytes, restart once the load is complete
    if (cmd.wr) begin
      lp_nxt = 1'b1;
      unique case (cw_r[5:4])
        itmr_pkg::RW_LSB: begin
          reload_new[7:0] = cmd.data;
        end
        itmr_pkg::RW_MSB: begin
          reload_new[15:8] = cmd.data;
        end
        itmr_pkg::RW_WORD: begin
          if (!wt_r) begin
            wt_new          = 1'b1;
            reload_new[7:0] = cmd.data;
          end else begin
            wt_new           = 1'b0;
            reload_new[15:8] = cmd.data;
          end
        end
        itmr_pkg::RW_LATCH: begin
          reload_new = reload_r;
        end
      endcase
      reload_nxt = reload_new;
      wt_nxt     = wt_new;
      if (cw_r[5:4] != itmr_pkg::RW_LATCH && !wt_new) begin
        count_nxt = itmr_pkg::start_value(reload_new, cw_r[0]);
        lp_nxt    = 1'b0;
      end
    end

    // count latch, ignored while a latch is held
    if (cmd.latch && !lv_r) begin
      lv_nxt      = 1'b1;
      latched_nxt = cur_val;
    end

    if (cmd.status) begin
      sp_nxt = 1'b1;
    end

    // programming control word
    if (cmd.prog) begin
      cw_nxt     = cmd.data;
      reload_nxt = 16'd0;
      rt_nxt     = 1'b0;
      wt_nxt     = 1'b0;
      lv_nxt     = 1'b0;
      sp_nxt     = 1'b0;
      lp_nxt     = 1'b1;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r      <= rst_cw;
      reload_r  <= rst_reload;
      count_r   <= itmr_pkg::start_value(rst_reload, rst_cw[0]);
      latched_r <= 16'd0;
      rt_r      <= 1'b0;
      wt_r      <= 1'b0;
      lv_r      <= 1'b0;
      lp_r      <= 1'b0;
      sp_r      <= 1'b0;
    end else begin
      cw_r      <= cw_nxt;
      reload_r  <= reload_nxt;
      count_r   <= count_nxt;
      latched_r <= latched_nxt;
      rt_r      <= rt_nxt;
      wt_r      <= wt_nxt;
      lv_r      <= lv_nxt;
      lp_r      <= lp_nxt;
      sp_r      <= sp_nxt;
    end
  end

endmodule

[hdl/interval_timer_three_channel.sv]
// ----------------------------------------------------------------------------
// interval_timer_three_channel
// Three channel interval timer driven by tick, read and write bus beats.
// ----------------------------------------------------------------------------
//
//   channel  modport  payload                        beat moves
//   in_ch    sink     action, port_select, data      tick, byte read, byte write
//   out_ch   source   read_data                      one byte per read beat
//
// One beat per cycle: an input register feeds the channel decode and update
// logic, whose read byte lands in the output register. A read raises
// out_ch.valid through the output register once its beat leaves the input
// register, and the byte is taken while out_ch.ready is high. Reset is
// synchronous and restores the power-on control words and reload values.
// While a result waits, a read beat holds in the input register and stalls
// the beats behind it; ticks and writes pass a full output register.
//
module interval_timer_three_channel #(
  parameter int NUM_CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  itmr_in_if.sink     in_ch,
  itmr_out_if.source  out_ch
);

  logic       in_valid_r;
  logic [1:0] act_r;
  logic [1:0] port_r;
  logic [7:0] data_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;

  logic       in_ready;
  logic       is_read;
  logic       fire;
  logic       ctrl_wr;
  logic       readback;
  logic [7:0] chan_or;
  logic [7:0] read_byte;

  logic [7:0]          chan_byte [NUM_CHANNELS];
  itmr_pkg::chan_cmd_t chan_cmd  [NUM_CHANNELS];

  // stage handshake, reads wait for a free output register
  assign is_read  = (act_r == itmr_pkg::ACT_READ);
  assign fire     = in_valid_r && (!is_read || !out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || fire;
  assign in_ch.ready = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      act_r  <= in_ch.action;
      port_r <= in_ch.port_select;
      data_r <= in_ch.data;
    end
  end

  // control word decode shared by all channels
  assign ctrl_wr  = fire && (act_r == itmr_pkg::ACT_WRITE) && (port_r == itmr_pkg::PORT_CTRL);
  assign readback = (data_r[7:6] == itmr_pkg::CH_READBACK);

  // channels
  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_chan
    always_comb begin
      chan_cmd[k].tick   = fire && (act_r == itmr_pkg::ACT_TICK);
      chan_cmd[k].rd     = fire && is_read && (port_r == 2'(k));
      chan_cmd[k].wr     = fire && (act_r == itmr_pkg::ACT_WRITE) && (port_r == 2'(k));
      chan_cmd[k].prog   = ctrl_wr && !readback && (data_r[7:6] == 2'(k)) &&
                           (data_r[5:4] != itmr_pkg::RW_LATCH);
      chan_cmd[k].latch  = ctrl_wr &&
                           ((!readback && (data_r[7:6] == 2'(k)) &&
                             (data_r[5:4] == itmr_pkg::RW_LATCH)) ||
                            (readback && data_r[k+1] && !data_r[5]));
      chan_cmd[k].status = ctrl_wr && readback && data_r[k+1] && !data_r[4];
      chan_cmd[k].data   = data_r;
    end

    itmr_channel #(
      .CH_ID (k)
    ) u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (chan_cmd[k]),
      .rd_byte (chan_byte[k])
    );
  end

  // read byte select, idle channels drive zero
  always_comb begin
    chan_or = 8'd0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      chan_or = chan_or | chan_byte[k];
    end
    if (port_r == itmr_pkg::PORT_CTRL || int'(port_r) >= NUM_CHANNELS) begin
      read_byte = itmr_pkg::CTRL_READ_BYTE;
    end else begin
      read_byte = chan_or;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && is_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_read) begin
      out_data_r <= read_byte;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;

`ifndef SYNTHESIS
  // a read that leaves the stage always shows up as a result beat
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_read |=> out_valid_r)
    else $error("read beat did not reach the output register");

  // ticks and writes never stall in the stage
  a_nonread_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !is_read |-> fire)
    else $error("non-read beat stalled");

  // a read must not overwrite an unaccepted result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && in_valid_r && is_read |-> !fire)
    else $error("read beat overwrote a pending result");

  // a held result keeps its byte while stalled
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result changed");
`endif

endmodule
